@@ hdl/tbp_pkg.sv @@
// Package for the trinomial branch probability unit.
// Holds register addresses, fixed-point constants and the style codes.
`timescale 1ns / 1ps
package tbp_pkg;
  localparam logic [63:0] JmaxConst    = 64'd790273982;
  localparam logic signed [63:0] Q30Sixth      = 64'sd178956971;
  localparam logic signed [63:0] Q30TwoThirds  = 64'sd715827883;
  localparam logic signed [63:0] Q30MinusThird = -64'sd357913941;
  localparam logic signed [63:0] Q30SevenSixth = 64'sd1252698795;

  typedef enum logic [1:0] {
    STYLE_CENTER = 2'd0,
    STYLE_UP     = 2'd1,
    STYLE_DOWN   = 2'd2
  } style_t;

  localparam logic [3:0] AddrReversion  = 4'h0;
  localparam logic [3:0] AddrTimeStep   = 4'h4;
  localparam logic [3:0] AddrVolatility = 4'h8;

  // Clamp a 64-bit signed value into the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

  // Halve rounding toward minus infinity.
  function automatic logic signed [63:0] half_down(input logic signed [63:0] v);
    half_down = v >>> 1;
  endfunction
endpackage

@@ hdl/trinomial_branch_probabilities.sv @@
// Top level of the trinomial branch probability unit; uses tbp_pkg.
// done strobes after start is accepted, through the stage registers v1, v2, v3, v4 and v5.
// Throughput: one node per cycle while busy is low; the receiver cannot stall, busy is high only in the derive pass.
// Derive pass (a*dt, jmax, sqrt(3*dt), spacing) after reset and each register write, through a serial
// divider and square root; the divider is skipped when a*dt is zero.
// Reset is synchronous, active high, and restores the register defaults.
`timescale 1ns / 1ps
module trinomial_branch_probabilities
  import tbp_pkg::*;
#(
  parameter int MAX_TIME_INDEX_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        slice_index,
  input  logic signed [11:0] node_offset,
  output logic               done,
  output logic [1:0]         branch_kind,
  output logic signed [31:0] prob_up,
  output logic signed [31:0] prob_mid,
  output logic signed [31:0] prob_down,
  output logic signed [31:0] rate_value,
  output logic [12:0]        state_count
);
  localparam int TBits = (MAX_TIME_INDEX_BITS < 12) ? MAX_TIME_INDEX_BITS : 12;
  localparam logic [11:0] TMask = 12'((13'd1 << TBits) - 13'd1);

  logic [31:0] mean_reversion, time_step, volatility;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Hold the registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_reversion <= 32'd6554;
      time_step      <= 32'd65536;
      volatility     <= 32'd655;
    end else if (cfg_wr) begin
      unique case (paddr)
        AddrReversion:  mean_reversion <= pwdata;
        AddrTimeStep:   time_step      <= pwdata;
        AddrVolatility: volatility     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrReversion:  prdata = mean_reversion;
      AddrTimeStep:   prdata = time_step;
      AddrVolatility: prdata = volatility;
      default:        prdata = 32'd0;
    endcase
  end

  // Derive sequencer: product, ceil division, square root, spacing.
  typedef enum logic [2:0] {S_MUL, S_DIV, S_SQRT, S_SPACE, S_RUN} seq_t;
  seq_t        seq;
  logic [63:0] p_reg, jmax, d_reg;
  logic [63:0] rem, quo, sq_v, sq_res, sq_bit;
  logic [5:0]  cnt;
  logic [31:0] r_reg;
  logic [64:0] rem_sh;

  assign rem_sh = {rem, quo[63]};

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      seq <= S_MUL;
    end else begin
      unique case (seq)
        S_MUL: begin
          p_reg  <= 64'(mean_reversion) * 64'(time_step);
          rem    <= 64'd0;
          quo    <= JmaxConst;
          cnt    <= 6'd0;
          sq_v   <= 64'(time_step) * 64'd3 << 16;
          sq_res <= 64'd0;
          sq_bit <= 64'd1 << 62;
          seq    <= S_DIV;
        end
        S_DIV: begin
          if (p_reg == 64'd0) begin
            jmax <= 64'hffffffff;
            seq  <= S_SQRT;
          end else begin
            if (rem_sh >= {1'b0, p_reg}) begin
              rem <= 64'(rem_sh - {1'b0, p_reg});
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh[63:0];
              quo <= {quo[62:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
            if (cnt == 6'd63) seq <= S_SPACE;
          end
        end
        S_SPACE: begin
          if (p_reg != 64'd0) jmax <= quo + {63'd0, rem != 64'd0};
          seq <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_bit == 64'd0) begin
            r_reg <= sq_res[31:0];
            seq   <= S_RUN;
          end else begin
            if (sq_v >= sq_res + sq_bit) begin
              sq_v   <= sq_v - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_RUN: d_reg <= 64'(volatility) * 64'(r_reg);
        default: seq <= S_MUL;
      endcase
    end
  end

  // The spacing product is registered in the run state; busy stays high until the cycle after, when d_reg holds it.
  logic run_ok;
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) run_ok <= 1'b0;
    else run_ok <= (seq == S_RUN);
  end
  assign busy = !run_ok;

  // Stage 1: node magnitude, counts, style decision.
  logic        v1, neg1;
  logic [11:0] aj1;
  logic [1:0]  st1;
  logic [12:0] n1;
  logic [64:0] ca, cb, cb1, nn, nn1;
  logic        clamp;
  logic [11:0] tm;
  logic signed [64:0] js, jm;

  always_comb begin
    tm  = slice_index & TMask;
    ca  = {jmax, 1'b1};
    cb  = 65'({tm, 1'b1});
    cb1 = cb + 65'd2;
    nn  = (ca < cb) ? ca : cb;
    nn1 = (ca < cb1) ? ca : cb1;
    clamp = (nn < cb) || (nn == nn1);
    js = 65'(node_offset);
    jm = $signed({1'b0, jmax});
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start && !busy;
    neg1 <= node_offset[11];
    aj1  <= node_offset[11] ? 12'(-node_offset) : node_offset;
    n1   <= nn[12:0];
    if (clamp && js <= -jm) st1 <= STYLE_UP;
    else if (clamp && js >= jm) st1 <= STYLE_DOWN;
    else st1 <= STYLE_CENTER;
  end

  // Stage 2: |j|*p and |j|*d; both operands fit the width limits.
  logic        v2, neg2, ovx2, ovr2;
  logic [1:0]  st2;
  logic [12:0] n2;
  logic [75:0] jp2, jd2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    neg2 <= neg1; st2 <= st1; n2 <= n1;
    jp2  <= 76'(aj1) * 76'(p_reg);
    jd2  <= 76'(aj1) * 76'(d_reg);
    ovx2 <= 1'b0; ovr2 <= 1'b0;
  end

  // Stage 3: round and cap x; round, sign and saturate rate.
  logic        v3, neg3;
  logic [1:0]  st3;
  logic [12:0] n3;
  logic [31:0] mq3;
  logic [31:0] rate3;
  logic [75:0] mqw, mw;
  always_comb begin
    mqw = (jp2 + 76'd2) >> 2;
    mw  = (jd2 + 76'd32768) >> 16;
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    neg3 <= neg2; st3 <= st2; n3 <= n2;
    mq3  <= (ovx2 || mqw > 76'hffffffff) ? 32'hffffffff : mqw[31:0];
    if (ovr2 || mw >= 76'h80000000)
      rate3 <= neg2 ? 32'h80000000 : 32'h7fffffff;
    else
      rate3 <= neg2 ? 32'(-mw[31:0]) : mw[31:0];
  end

  // Stage 4: square of x.
  logic        v4, neg4;
  logic [1:0]  st4;
  logic [12:0] n4;
  logic [31:0] mq4, rate4;
  logic [63:0] sq4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    neg4 <= neg3; st4 <= st3; n4 <= n3; mq4 <= mq3; rate4 <= rate3;
    sq4  <= 64'(mq3) * 64'(mq3);
  end

  // Stage 5: scale the square and sign x.
  logic        v5;
  logic [1:0]  st5;
  logic [12:0] n5;
  logic [31:0] rate5;
  logic signed [63:0] x5, s5;
  logic [63:0] sr;
  always_comb sr = (sq4 + 64'd536870912) >> 30;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    st5 <= st4; n5 <= n4; rate5 <= rate4;
    x5  <= neg4 ? -$signed(64'(mq4)) : $signed(64'(mq4));
    s5  <= $signed(sr);
  end

  // Stage 6: probabilities per branch style, saturate, strobe out.
  logic signed [63:0] pu, pm, pd;
  always_comb begin
    case (st5)
      STYLE_UP: begin
        pu = Q30Sixth + half_down(s5 + x5);
        pm = Q30MinusThird - s5 - 2 * x5;
        pd = Q30SevenSixth + half_down(s5 + 3 * x5);
      end
      STYLE_DOWN: begin
        pu = Q30SevenSixth + half_down(s5 - 3 * x5);
        pm = Q30MinusThird - s5 + 2 * x5;
        pd = Q30Sixth + half_down(s5 - x5);
      end
      default: begin
        pu = Q30Sixth + half_down(s5 - x5);
        pm = Q30TwoThirds - s5;
        pd = Q30Sixth + half_down(s5 + x5);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v5;
    branch_kind  <= st5;
    prob_up      <= sat32(pu);
    prob_mid     <= sat32(pm);
    prob_down    <= sat32(pd);
    rate_value   <= rate5;
    state_count  <= n5;
  end
endmodule

@@ tb/sv/trinomial_branch_probabilities_test.sv @@
// Testbench for the trinomial branch probability unit: directed and random nodes,
// register sweeps over the APB port, each result checked against a local predictor.
// Depends on tbp_pkg and trinomial_branch_probabilities.
`timescale 1ns / 1ps
module trinomial_branch_probabilities_test;
  import tbp_pkg::*;

  typedef struct {
    style_t             style;
    logic signed [31:0] up;
    logic signed [31:0] mid;
    logic signed [31:0] down;
    logic signed [31:0] rate;
    logic [12:0]        count;
  } branch_beat_t;

  localparam int CycleLimit = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic [11:0]        slice_index = '0;
  logic signed [11:0] node_offset = '0;
  logic               done;
  logic [1:0]         branch_kind;
  logic signed [31:0] prob_up;
  logic signed [31:0] prob_mid;
  logic signed [31:0] prob_down;
  logic signed [31:0] rate_value;
  logic [12:0]        state_count;

  // register shadows
  longint unsigned reversion_q = 6554;
  longint unsigned step_q = 65536;
  longint unsigned vol_q = 655;

  branch_beat_t expected_beats[$];
  int mismatches = 0;
  int cycles = 0;
  int sender_idle_pct = 0;

  trinomial_branch_probabilities uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .slice_index, .node_offset, .done, .branch_kind,
    .prob_up, .prob_mid, .prob_down, .rate_value, .state_count
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL trinomial_branch_probabilities");
      $finish;
    end
  end

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned branch_limit();
    longint unsigned p;
    p = reversion_q * step_q;
    if (p == 0) return 64'hffffffff;
    return JmaxConst / p + ((JmaxConst % p) != 0 ? 1 : 0);
  endfunction

  // Work out the branch geometry, probabilities and rate of one node.
  function automatic branch_beat_t predict_branch(input logic [11:0] t_in,
                                                  input logic signed [11:0] j_in);
    longint unsigned t, aj, p, jmax, n, n_next, mq, r, d, m, v, bit_w;
    longint j, x, s, pu, pm, pd, rt;
    logic clamp;
    branch_beat_t e;
    t = t_in;
    j = j_in;
    aj = (j < 0) ? -j : j;
    p = reversion_q * step_q;
    jmax = branch_limit();
    n = (2 * jmax + 1 < 2 * t + 1) ? 2 * jmax + 1 : 2 * t + 1;
    n_next = (2 * jmax + 1 < 2 * t + 3) ? 2 * jmax + 1 : 2 * t + 3;
    clamp = (n < 2 * t + 1) || (n == n_next);
    e.style = STYLE_CENTER;
    if (clamp && j <= -longint'(jmax)) e.style = STYLE_UP;
    else if (clamp && j >= longint'(jmax)) e.style = STYLE_DOWN;

    // x = j*a*dt in Q.30 with capped magnitude
    if (aj != 0 && p > (64'd1 << 36) / aj) mq = 64'hffffffff;
    else begin
      mq = (aj * p + 2) >> 2;
      if (mq > 64'hffffffff) mq = 64'hffffffff;
    end
    x = (j < 0) ? -longint'(mq) : longint'(mq);
    s = longint'((mq * mq + (64'd1 << 29)) >> 30);
    case (e.style)
      STYLE_UP: begin
        pu = Q30Sixth + ((s + x) >>> 1);
        pm = Q30MinusThird - s - 2 * x;
        pd = Q30SevenSixth + ((s + 3 * x) >>> 1);
      end
      STYLE_DOWN: begin
        pu = Q30SevenSixth + ((s - 3 * x) >>> 1);
        pm = Q30MinusThird - s + 2 * x;
        pd = Q30Sixth + ((s - x) >>> 1);
      end
      default: begin
        pu = Q30Sixth + ((s - x) >>> 1);
        pm = Q30TwoThirds - s;
        pd = Q30Sixth + ((s + x) >>> 1);
      end
    endcase

    // floor square root of 3*dt in Q16.16
    v = (3 * step_q) << 16;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v -= r + bit_w;
        r = (r >> 1) + bit_w;
      end else r >>= 1;
      bit_w >>= 2;
    end
    d = vol_q * r;
    if (aj != 0 && d > (64'd1 << 62) / aj) rt = (j < 0) ? -64'sd2147483648 : 64'sd2147483647;
    else begin
      m = (aj * d + (64'd1 << 15)) >> 16;
      if (m > (64'd1 << 31)) m = 64'd1 << 31;
      rt = clip32((j < 0) ? -longint'(m) : longint'(m));
    end
    e.up = 32'(clip32(pu));
    e.mid = 32'(clip32(pm));
    e.down = 32'(clip32(pd));
    e.rate = 32'(rt);
    e.count = n[12:0];
    return e;
  endfunction

  // Compare each done beat with the oldest expectation.
  always @(posedge clk) begin
    branch_beat_t e;
    if (!rst && done) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, style %0d", $time, branch_kind);
        mismatches++;
      end else begin
        e = expected_beats.pop_front();
        if (branch_kind !== e.style) begin
          $display("%0t: branch_kind exp %0d got %0d", $time, e.style, branch_kind);
          mismatches++;
        end
        if (prob_up !== e.up) begin
          $display("%0t: prob_up exp %0d got %0d", $time, e.up, prob_up);
          mismatches++;
        end
        if (prob_mid !== e.mid) begin
          $display("%0t: prob_mid exp %0d got %0d", $time, e.mid, prob_mid);
          mismatches++;
        end
        if (prob_down !== e.down) begin
          $display("%0t: prob_down exp %0d got %0d", $time, e.down, prob_down);
          mismatches++;
        end
        if (rate_value !== e.rate) begin
          $display("%0t: rate_value exp %0d got %0d", $time, e.rate, rate_value);
          mismatches++;
        end
        if (state_count !== e.count) begin
          $display("%0t: state_count exp %0d got %0d", $time, e.count, state_count);
          mismatches++;
        end
      end
    end
  end

  // Send one node; leaves start high, unless a random idle gap drops it, so back-to-back beats stay unbroken.
  task automatic send_node(input logic [11:0] t, input logic signed [11:0] j);
    start = 1'b1;
    slice_index = t;
    node_offset = j;
    do @(posedge clk); while (busy);
    expected_beats.push_back(predict_branch(t, j));
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
  endtask

  // Drop start, wait for all results, then let the pipeline drain.
  task automatic drain_results();
    start = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
    drain_results();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (addr)
      AddrReversion: reversion_q = value;
      AddrTimeStep: step_q = value;
      default: vol_q = value;
    endcase
  endtask

  task automatic write_all(input logic [31:0] a, input logic [31:0] dt,
                           input logic [31:0] vol);
    write_reg(AddrReversion, a);
    write_reg(AddrTimeStep, dt);
    write_reg(AddrVolatility, vol);
  endtask

  // Reset registers: jmax is 2, so clamping starts at slice 2.
  task automatic test_directed();
    send_node(12'd0, 12'sd0);
    send_node(12'd1, 12'sd1);
    send_node(12'd1, -12'sd1);
    send_node(12'd2, 12'sd2);
    send_node(12'd2, -12'sd2);
    send_node(12'd5, 12'sd3);
    send_node(12'd5, -12'sd3);
    send_node(12'd5, 12'sd1);
    send_node(12'd4095, 12'sd2047);
    send_node(12'd4095, -12'sd2048);
    send_node(12'd3, 12'sd0);
    send_node(12'hAAA, 12'sh555);
    send_node(12'h555, -12'sh556);
  endtask

  // Register extremes: tiny p, capped x, zero and full volatility.
  task automatic test_extremes();
    write_all(32'd1, 32'd1, 32'hffffffff);
    send_node(12'd4095, 12'sd2047);
    send_node(12'd0, -12'sd2048);
    send_node(12'd7, 12'sd1);
    write_all(32'hffffffff, 32'hffffffff, 32'd0);
    send_node(12'd0, 12'sd0);
    send_node(12'd1, 12'sd1);
    send_node(12'd1, -12'sd1);
    send_node(12'd9, 12'sd2047);
    send_node(12'd9, -12'sd2048);
    write_all(32'h00010000, 32'hffffffff, 32'hffffffff);
    send_node(12'd3, 12'sd2047);
    send_node(12'd3, -12'sd2048);
    send_node(12'd3, -12'sd1);
  endtask

  // Random nodes over several random settings; most land near the clamp edge.
  task automatic test_random(input int idle_pct, input int beats, input bit hold_off);
    longint unsigned lim;
    logic [11:0] t;
    logic signed [11:0] j;
    logic [31:0] a, dt;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < beats; i++) begin
      if (i % 70 == 0) begin
        a = $urandom >> $urandom_range(31);
        dt = $urandom >> $urandom_range(31);
        write_all((a == 0) ? 32'd1 : a, (dt == 0) ? 32'd1 : dt,
                  $urandom >> $urandom_range(32));
      end
      if (hold_off && i == beats / 2) drain_results();
      lim = branch_limit();
      if (lim > 2000) lim = 2000;
      if ($urandom_range(3) == 0) begin
        t = 12'($urandom);
        j = 12'($urandom);
      end else begin
        t = 12'($urandom_range(int'(lim) + 3, 0));
        j = 12'($urandom_range(int'(lim) + 2, 0));
        if ($urandom_range(1)) j = -j;
      end
      send_node(t, j);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_extremes();
    test_random(6, 280, 1'b1);
    test_random(85, 280, 1'b0);
    test_random(0, 280, 1'b0);
    drain_results();
    if (mismatches == 0) $display("PASS trinomial_branch_probabilities");
    else $display("FAIL trinomial_branch_probabilities");
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/tbp_pkg.sv
hdl/trinomial_branch_probabilities.sv
tb/sv/trinomial_branch_probabilities_test.sv
